// File: rtl/stfs_pkg.sv
// ----------------------------------------------------------------------------
// stfs_pkg
// Shared types and constants for the slot table with free search.
// ----------------------------------------------------------------------------
package stfs_pkg;

  localparam int SLOTS_DEF        = 256;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  slot;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0]  slot_used;
    logic [31:0] read_value;
    logic        present;
    logic        full_res;
    logic [8:0]  occupied;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit_add;
    logic commit_access;
  } cmd_t;

  typedef struct packed {
    logic in_add;
    logic word_free;
    logic exhausted;
  } status_t;

endpackage

// File: rtl/stfs_ram.sv
// ----------------------------------------------------------------------------
// stfs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/stfs_ctrl.sv
// ----------------------------------------------------------------------------
// stfs_ctrl
// Sequencer: accept, access or word scan, commit, result strobe.
// ----------------------------------------------------------------------------
module stfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  stfs_pkg::status_t status,
  output stfs_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  stfs_pkg::state_t state;
  stfs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stfs_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit_add | cmd.commit_access;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      stfs_pkg::ST_IDLE: begin
        if (start) begin
          state_next = status.in_add ? stfs_pkg::ST_SEARCH : stfs_pkg::ST_ACCESS;
        end
      end
      stfs_pkg::ST_ACCESS: begin
        state_next = stfs_pkg::ST_IDLE;
      end
      stfs_pkg::ST_SEARCH: begin
        if (status.word_free || status.exhausted) begin
          state_next = stfs_pkg::ST_IDLE;
        end
      end
      default: state_next = stfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      stfs_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      stfs_pkg::ST_ACCESS: begin
        cmd.commit_access = 1'b1;
      end
      stfs_pkg::ST_SEARCH: begin
        cmd.commit_add = status.word_free | status.exhausted;
        cmd.step       = ~(status.word_free | status.exhausted);
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: rtl/stfs_datapath.sv
// ----------------------------------------------------------------------------
// stfs_datapath
// Valid bitmap, hint, count, word-at-a-time free scan and result register.
// ----------------------------------------------------------------------------
module stfs_datapath #(
  parameter int SLOTS        = stfs_pkg::SLOTS_DEF,
  parameter int ELEMENT_BITS = stfs_pkg::ELEMENT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  stfs_pkg::item_t          item,
  input  stfs_pkg::cmd_t           cmd,
  output stfs_pkg::status_t        status,
  output stfs_pkg::result_t        result,
  output logic                     ram_we,
  output logic [$clog2(SLOTS)-1:0] ram_waddr,
  output logic [ELEMENT_BITS-1:0]  ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(SLOTS)-1:0] ram_raddr,
  input  logic [ELEMENT_BITS-1:0]  ram_rdata
);

  localparam int AW     = $clog2(SLOTS);
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int LOG_W  = (AW < 5) ? AW : 5;
  localparam int W      = 1 << LOG_W;
  localparam int NW     = (SLOTS + W - 1) / W;
  localparam int PADDED = NW * W;
  localparam int WIX    = (NW > 1) ? $clog2(NW) : 1;
  localparam int WIW    = $clog2(NW + 1);
  localparam int XW     = AW + 9;

  localparam logic [WIW-1:0]    NW_C     = WIW'(NW);
  localparam logic [CW-1:0]     SLOTS_CW = CW'(SLOTS);
  localparam logic [XW-1:0]     SLOTS_X  = XW'(SLOTS);
  localparam logic [PADDED-1:0] PAD_ONES = ~({PADDED{1'b1}} >> (PADDED - SLOTS));

  stfs_pkg::item_t   it;
  stfs_pkg::result_t res_next;

  logic [SLOTS-1:0] valid;
  logic [CW-1:0]    hint;
  logic [CW-1:0]    hint_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [WIW-1:0]   widx;
  logic [WIW-1:0]   hint_word;

  logic [AW+7:0]    in_ext;
  logic [AW+7:0]    it_ext;
  logic [AW-1:0]    it_idx;
  logic             it_inside;
  logic             vbit;
  logic [ELEMENT_BITS-1:0] value_m;

  logic [PADDED-1:0] valid_pad;
  logic [WIX-1:0]    word_sel;
  logic [W-1:0]      word;
  logic [LOG_W-1:0]  lo_free;
  logic              has_free;
  logic [WIX+LOG_W-1:0] pos_w;
  logic [AW-1:0]     pos;
  logic              exhausted;

  logic              v_we;
  logic [AW-1:0]     v_idx;
  logic              v_val;

  assign in_ext    = {{AW{1'b0}}, item.slot};
  assign it_ext    = {{AW{1'b0}}, it.slot};
  assign it_idx    = it_ext[AW-1:0];
  assign it_inside = {1'b0, it_ext} < SLOTS_X;
  assign vbit      = valid[it_idx];
  assign value_m   = ELEMENT_BITS'(it.value);
  assign hint_word = WIW'(hint >> LOG_W);

  assign valid_pad = PADDED'(valid) | PAD_ONES;
  assign word_sel  = widx[WIX-1:0];
  assign word      = valid_pad[word_sel*W +: W];
  assign exhausted = (widx == NW_C);

  always_comb begin
    lo_free  = '0;
    has_free = 1'b0;
    for (int i = W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        lo_free  = LOG_W'(i);
        has_free = 1'b1;
      end
    end
  end

  assign pos_w = {word_sel, lo_free};
  assign pos   = pos_w[AW-1:0];

  assign status.in_add    = (item.kind == stfs_pkg::KIND_ADD);
  assign status.word_free = has_free & ~exhausted;
  assign status.exhausted = exhausted;

  assign ram_re    = cmd.load;
  assign ram_raddr = in_ext[AW-1:0];
  assign ram_wdata = value_m;

  always_comb begin
    count_next          = count;
    hint_next           = hint;
    v_we                = 1'b0;
    v_idx               = it_idx;
    v_val               = 1'b0;
    ram_we              = 1'b0;
    ram_waddr           = it_idx;
    res_next.slot_used  = it.slot;
    res_next.read_value = '0;
    res_next.present    = 1'b0;
    res_next.full_res   = 1'b0;
    if (cmd.commit_add) begin
      if (exhausted) begin
        res_next.slot_used = '0;
        res_next.full_res  = 1'b1;
        hint_next          = SLOTS_CW;
      end else begin
        v_we                = 1'b1;
        v_idx               = pos;
        v_val               = 1'b1;
        ram_we              = 1'b1;
        ram_waddr           = pos;
        count_next          = count + 1'b1;
        hint_next           = CW'(pos) + 1'b1;
        res_next.slot_used  = 8'(pos);
        res_next.read_value = 32'(value_m);
      end
    end else if (cmd.commit_access) begin
      unique case (it.kind)
        stfs_pkg::KIND_SET: begin
          if (it_inside) begin
            res_next.present    = vbit;
            res_next.read_value = 32'(value_m);
            v_we                = 1'b1;
            v_val               = 1'b1;
            ram_we              = 1'b1;
            if (!vbit) begin
              count_next = count + 1'b1;
            end
          end
        end
        stfs_pkg::KIND_REMOVE: begin
          if (it_inside) begin
            res_next.present = vbit;
            v_we             = 1'b1;
            if (vbit) begin
              res_next.read_value = 32'(ram_rdata);
              count_next          = count - 1'b1;
            end
            if ({1'b0, it_ext} < XW'(hint)) begin
              hint_next = CW'(it_idx);
            end
          end
        end
        stfs_pkg::KIND_READ: begin
          if (it_inside && vbit) begin
            res_next.present    = 1'b1;
            res_next.read_value = 32'(ram_rdata);
          end else begin
            res_next.read_value = 32'(value_m);
          end
        end
        default: begin
          res_next.slot_used = it.slot;
        end
      endcase
    end
    res_next.occupied = 9'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hint  <= '0;
      count <= '0;
      widx  <= '0;
    end else begin
      if (cmd.load) begin
        widx <= hint_word;
      end else if (cmd.step) begin
        widx <= widx + 1'b1;
      end
      if (v_we) begin
        valid[v_idx] <= v_val;
      end
      hint  <= hint_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= item;
    end
    if (cmd.commit_add || cmd.commit_access) begin
      result <= res_next;
    end
  end

endmodule

// File: rtl/slot_table_with_free_search_core.sv
// ----------------------------------------------------------------------------
// slot_table_with_free_search_core
// Slot table with a valid bitmap, lowest-free search from a hint, data RAM.
//
//   channel   direction  handshake                 payload
//   item      in         start & !busy             stfs_pkg::item_t
//   result    out        done, one cycle per beat  stfs_pkg::result_t
//
// Set, remove and read go through accept with RAM read, then commit.
// Add is accepted, then scans one 32-bit word of the valid bitmap per cycle
// from the hint's word; the scan ends on the first word with a free slot,
// or on the step that finds it past the last word, which gives a full result.
// The result beat is shown the cycle after commit; a new beat may be
// accepted in that cycle. Reset is synchronous; valid bits are flops and
// clear at once. done cannot be stalled.
// ----------------------------------------------------------------------------
module slot_table_with_free_search_core #(
  parameter int SLOTS        = stfs_pkg::SLOTS_DEF,
  parameter int ELEMENT_BITS = stfs_pkg::ELEMENT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  stfs_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output stfs_pkg::result_t result
);

  stfs_pkg::cmd_t    cmd;
  stfs_pkg::status_t status;

  logic                     ram_we;
  logic [$clog2(SLOTS)-1:0] ram_waddr;
  logic [ELEMENT_BITS-1:0]  ram_wdata;
  logic                     ram_re;
  logic [$clog2(SLOTS)-1:0] ram_raddr;
  logic [ELEMENT_BITS-1:0]  ram_rdata;

  stfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  stfs_datapath #(
    .SLOTS        (SLOTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  stfs_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/stfs_checker.sv
// ----------------------------------------------------------------------------
// stfs_checker
// Port-level checks on the slot table core, bound to the top level.
// ----------------------------------------------------------------------------
module stfs_checker #(
  parameter int SLOTS = stfs_pkg::SLOTS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input stfs_pkg::item_t   item,
  input logic              busy,
  input logic              done,
  input stfs_pkg::result_t result
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_access_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind != stfs_pkg::KIND_ADD) |-> ##2 done)
    else $error("set, remove or read result not two cycles after accept");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.full_res) |-> (result.occupied == 9'(SLOTS)))
    else $error("full flagged with free slots left");

endmodule

bind slot_table_with_free_search_core stfs_checker #(
  .SLOTS (SLOTS)
) u_stfs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// File: test/stfs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stfs_scoreboard
// Watches the item and result channels of the slot table core. Keeps its own
// copy of the valid bitmap, slot words, free hint and occupied count, works out
// the answer to every accepted item and compares each result beat, field by
// field, with the oldest answer still due.
// ----------------------------------------------------------------------------
module stfs_scoreboard
  import stfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  item_t       item,
  input  logic        done,
  input  result_t     result,
  output int unsigned fail_count,
  output int unsigned pending
);

  bit          shadow_valid [SLOTS_DEF];
  logic [31:0] shadow_data  [SLOTS_DEF];
  int          shadow_hint;
  int          shadow_count;
  result_t     answers_due [$];
  int unsigned errs;

  initial begin
    errs       = 0;
    fail_count = 0;
    pending    = 0;
  end

  function automatic result_t apply_table_op(item_t op);
    result_t r;
    int      pos;
    r           = '0;
    r.slot_used = op.slot;
    case (op.kind)
      KIND_ADD: begin
        pos = shadow_hint;
        while (pos < SLOTS_DEF && shadow_valid[pos]) pos++;
        if (pos >= SLOTS_DEF) begin
          shadow_hint = SLOTS_DEF;
          r.slot_used = '0;
          r.full_res  = 1'b1;
        end else begin
          shadow_valid[pos] = 1'b1;
          shadow_data[pos]  = op.value;
          shadow_count++;
          shadow_hint  = pos + 1;
          r.slot_used  = pos[7:0];
          r.read_value = op.value;
        end
      end
      KIND_SET: begin
        r.present = shadow_valid[op.slot];
        if (!shadow_valid[op.slot]) shadow_count++;
        shadow_valid[op.slot] = 1'b1;
        shadow_data[op.slot]  = op.value;
        r.read_value = op.value;
      end
      KIND_REMOVE: begin
        r.present = shadow_valid[op.slot];
        if (shadow_valid[op.slot]) begin
          r.read_value = shadow_data[op.slot];
          shadow_count--;
        end
        shadow_valid[op.slot] = 1'b0;
        if (int'(op.slot) < shadow_hint) shadow_hint = op.slot;
      end
      KIND_READ: begin
        if (shadow_valid[op.slot]) begin
          r.present    = 1'b1;
          r.read_value = shadow_data[op.slot];
        end else begin
          r.read_value = op.value;
        end
      end
      default: ;
    endcase
    r.occupied = shadow_count[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      shadow_hint  = 0;
      shadow_count = 0;
      answers_due.delete();
    end else begin
      // result beat first: it can never belong to an item accepted on this edge
      if (done) begin
        if (answers_due.size() == 0) begin
          errs++;
          $display("%0t: result beat with no answer due, got %h", $time, result);
        end else begin
          want = answers_due.pop_front();
          if (result !== want) begin
            errs++;
            if (result.slot_used !== want.slot_used)
              $display("%0t: slot_used expected %h actual %h", $time,
                       want.slot_used, result.slot_used);
            if (result.read_value !== want.read_value)
              $display("%0t: read_value expected %h actual %h", $time,
                       want.read_value, result.read_value);
            if (result.present !== want.present)
              $display("%0t: present expected %b actual %b", $time,
                       want.present, result.present);
            if (result.full_res !== want.full_res)
              $display("%0t: full_res expected %b actual %b", $time,
                       want.full_res, result.full_res);
            if (result.occupied !== want.occupied)
              $display("%0t: occupied expected %0d actual %0d", $time,
                       want.occupied, result.occupied);
          end
        end
      end
      if (start && !busy) answers_due.push_back(apply_table_op(item));
    end
    fail_count <= errs;
    pending    <= answers_due.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the slot table core: a directed opening over the edge cases,
// then phases of random operations that fill the table past full, churn it,
// drain it and work a narrow window of slots. The scoreboard does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
  import stfs_pkg::*;

  localparam int STALL_LIMIT = 500;

  logic        clk   = 1'b0;
  logic        rst   = 1'b1;
  logic        start = 1'b0;
  item_t       item  = '0;
  logic        busy;
  logic        done;
  result_t     result;
  int unsigned fail_count;
  int unsigned pending;
  int          stall_cycles = 0;
  bit          idle_on = 1'b1;

  always #5 clk = ~clk;

  slot_table_with_free_search_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  stfs_scoreboard chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // start stays high straight into the next beat unless a gap is drawn
  task automatic send_op(logic [1:0] k, logic [7:0] s, logic [31:0] v);
    item_t op;
    op.kind  = k;
    op.slot  = s;
    op.value = v;
    item  <= op;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (idle_on && $urandom_range(99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic run_mix(int n, int add_w, int set_w, int rem_w, int slot_top);
    int          pick;
    logic [1:0]  k;
    logic [7:0]  s;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < add_w) k = KIND_ADD;
      else if (pick < add_w + set_w) k = KIND_SET;
      else if (pick < add_w + set_w + rem_w) k = KIND_REMOVE;
      else k = KIND_READ;
      s = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(slot_top));
      case ($urandom_range(9))
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom;
      endcase
      send_op(k, s, v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, extremes, overwrite, remove of empty and occupied slots
    send_op(KIND_READ,   8'd0,   32'h0000_0000);
    send_op(KIND_READ,   8'd255, 32'hFFFF_FFFF);
    send_op(KIND_REMOVE, 8'd7,   32'h1234_5678);
    send_op(KIND_ADD,    8'd200, 32'hFFFF_FFFF);
    send_op(KIND_ADD,    8'd0,   32'h0000_0000);
    send_op(KIND_ADD,    8'd255, 32'hA5A5_A5A5);
    send_op(KIND_SET,    8'd255, 32'hFFFF_FFFF);
    send_op(KIND_SET,    8'd255, 32'h1234_5678);
    send_op(KIND_READ,   8'd255, 32'h0000_0000);
    send_op(KIND_READ,   8'd0,   32'hFFFF_FFFF);
    send_op(KIND_REMOVE, 8'd1,   32'h0000_0000);
    send_op(KIND_ADD,    8'd0,   32'h5A5A_5A5A);
    send_op(KIND_REMOVE, 8'd1,   32'h0000_0000);
    send_op(KIND_REMOVE, 8'd0,   32'hFFFF_FFFF);
    send_op(KIND_ADD,    8'd0,   32'h8000_0001);
    send_op(KIND_REMOVE, 8'd255, 32'h0000_0000);
    send_op(KIND_REMOVE, 8'd255, 32'h0000_0000);
    send_op(KIND_SET,    8'd0,   32'h0000_0000);
    send_op(KIND_SET,    8'd128, 32'h8000_0000);
    send_op(KIND_READ,   8'd128, 32'h0000_0000);
    send_op(KIND_READ,   8'd129, 32'h7FFF_FFFF);
    send_op(KIND_ADD,    8'd0,   32'h0F0F_F0F0);

    // fill past full, churn near full with no gaps, drain, narrow window, mix
    run_mix(420, 80, 5, 5, 255);
    idle_on = 1'b0;
    run_mix(250, 40, 10, 30, 255);
    idle_on = 1'b1;
    run_mix(400, 10, 5, 65, 255);
    run_mix(300, 25, 25, 25, 15);
    run_mix(280, 25, 25, 25, 255);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
